// ===== src/u8h_pkg.sv =====
// shared types, codes and constants of the utf-8 to hangul pair decoder
`timescale 1ns / 1ps

package u8h_pkg;

	// result status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_LEAD    = 3'd1;
	localparam logic [2:0] ST_BAD_CONT    = 3'd2;
	localparam logic [2:0] ST_TRUNC       = 3'd3;
	localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

	// input kind carried on tuser
	localparam logic FUNC_DATA = 1'b0;
	localparam logic FUNC_EOS  = 1'b1;

	// source modes
	localparam logic MODE_UTF8 = 1'b0;
	localparam logic MODE_RAW  = 1'b1;

	// code point ranges and offsets
	localparam logic [20:0] CP_BOM        = 21'h00FEFF;
	localparam logic [20:0] CP_JAMO_LO    = 21'h001100;
	localparam logic [20:0] CP_JAMO_HI    = 21'h0011FF;
	localparam logic [20:0] CP_SYL_LO     = 21'h00AC00;
	localparam logic [20:0] CP_SYL_HI     = 21'h00D7A3;
	localparam logic [15:0] JAMO_ADD      = 16'h3000;  // same as minus 0xD000 modulo 2^16
	localparam logic [15:0] SYL_SUB       = 16'h6000;

	// ascii handling
	localparam logic [7:0] BYTE_CR      = 8'h0D;
	localparam logic [7:0] BYTE_LF      = 8'h0A;
	localparam logic [7:0] BYTE_SPACE   = 8'h20;
	localparam logic [7:0] BYTE_HIGHBIT = 8'h80;

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEFAULT = 4;

	// one queued action: a single result or a pair of ok bytes
	typedef struct packed {
		logic       pair;    // two results: b0 then b1
		logic [7:0] b0;      // high byte of a pair
		logic [7:0] b1;      // low byte of a pair, or the single byte
		logic [2:0] status;  // status of a single result
	} entry_t;

endpackage

// ===== src/utf8_to_hangul_pair_decoder.sv =====
// top level of the utf-8 to hangul pair decoder
`timescale 1ns / 1ps

// Byte stream in on the s_ side: tdata is the byte, tuser is 0 for a data byte
// and 1 for end of stream. Display bytes out on the m_ side: tdata is the byte,
// tuser the status (0 ok, 1 bad lead, 2 bad continuation, 3 truncated,
// 4 unsupported), tlast marks the final result caused by one input byte.
// The cfg channel writes source_mode (0 decode utf-8, 1 raw passthrough);
// write it only while the block is idle. cfg_ready is always high.
// One input byte is taken per cycle while the queue is not full. A byte is
// decoded at the edge that takes it; its action enters a small queue and
// from there the output register, which drives m_tvalid. A jamo or syllable gives
// two results, so the output register, one result per cycle while m_tready
// is high, sets the sustained rate. When the receiver stalls, the output
// register holds and the queue fills; s_tready drops only once it is full.
// After an error result the block halts and drops all input until reset.
// Reset clears the sequence state, the halt flag, the queue and source_mode.

module utf8_to_hangul_pair_decoder
	import u8h_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tuser,   // [0] func
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [2:0] m_tuser,   // [2:0] status
	output logic       m_tlast,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data
);

	logic   push;
	entry_t push_entry;
	logic   pop;
	entry_t head;
	logic   full;
	logic   empty;

	assign cfg_ready = 1'b1;

	// decode and classify
	u8h_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_mode   (cfg_data),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.func       (s_tuser),
		.in_byte    (s_tdata),
		.push       (push),
		.push_entry (push_entry),
		.queue_full (full)
	);

	// action queue
	u8h_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (full),
		.empty      (empty)
	);

	// result emitter
	u8h_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.status    (m_tuser),
		.last      (m_tlast)
	);

endmodule

// ===== src/u8h_front.sv =====
// front part: accepts bytes, tracks utf-8 sequence state and queues actions
`timescale 1ns / 1ps

module u8h_front
	import u8h_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_mode,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [7:0]  in_byte,
	output logic        push,
	output entry_t      push_entry,
	input  logic        queue_full
);

	logic        source_mode_q;
	logic [1:0]  bytes_remaining_q;
	logic [20:0] code_acc_q;
	logic        halted_q;

	logic [1:0]  bytes_remaining_d;
	logic [20:0] code_acc_d;
	logic        halted_d;
	logic        push_c;
	logic [20:0] cp;
	logic        accept;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign cp       = {code_acc_q[14:0], in_byte[5:0]};

	// next state and action for one byte
	always_comb begin
		bytes_remaining_d = bytes_remaining_q;
		code_acc_d        = code_acc_q;
		halted_d          = halted_q;
		push_c            = 1'b0;
		push_entry        = '0;
		if (!halted_q) begin
			if (func == FUNC_EOS) begin
				if (bytes_remaining_q != 2'd0) begin
					halted_d          = 1'b1;
					bytes_remaining_d = 2'd0;
					push_c            = 1'b1;
					push_entry.status = ST_TRUNC;
				end
			end else if (source_mode_q == MODE_RAW) begin
				bytes_remaining_d = 2'd0;
				push_c            = 1'b1;
				push_entry.b1     = in_byte;
				push_entry.status = ST_OK;
			end else if (bytes_remaining_q == 2'd0) begin
				priority if (in_byte[7] == 1'b0) begin
					if (in_byte == BYTE_CR || in_byte == BYTE_LF) begin
						push_c        = 1'b1;
						push_entry.b1 = in_byte;
					end else if (in_byte >= BYTE_SPACE) begin
						push_c        = 1'b1;
						push_entry.b1 = in_byte | BYTE_HIGHBIT;
					end
				end else if (in_byte[7:5] == 3'b110) begin
					bytes_remaining_d = 2'd1;
					code_acc_d        = {16'd0, in_byte[4:0]};
				end else if (in_byte[7:4] == 4'b1110) begin
					bytes_remaining_d = 2'd2;
					code_acc_d        = {17'd0, in_byte[3:0]};
				end else if (in_byte[7:3] == 5'b11110) begin
					bytes_remaining_d = 2'd3;
					code_acc_d        = {18'd0, in_byte[2:0]};
				end else begin
					halted_d          = 1'b1;
					push_c            = 1'b1;
					push_entry.status = ST_BAD_LEAD;
				end
			end else if (in_byte[7:6] != 2'b10) begin
				halted_d          = 1'b1;
				bytes_remaining_d = 2'd0;
				push_c            = 1'b1;
				push_entry.status = ST_BAD_CONT;
			end else begin
				code_acc_d        = cp;
				bytes_remaining_d = bytes_remaining_q - 2'd1;
				if (bytes_remaining_q == 2'd1) begin
					priority if (cp == CP_BOM) begin
						push_c = 1'b0;
					end else if (cp >= CP_JAMO_LO && cp <= CP_JAMO_HI) begin
						push_c          = 1'b1;
						push_entry.pair = 1'b1;
						{push_entry.b0, push_entry.b1} = cp[15:0] + JAMO_ADD;
					end else if (cp >= CP_SYL_LO && cp <= CP_SYL_HI) begin
						push_c          = 1'b1;
						push_entry.pair = 1'b1;
						{push_entry.b0, push_entry.b1} = cp[15:0] - SYL_SUB;
					end else begin
						halted_d          = 1'b1;
						push_c            = 1'b1;
						push_entry.status = ST_UNSUPPORTED;
					end
				end
			end
		end
	end

	assign push = accept && push_c;

	// mode register, to be written while idle; the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_mode_q <= MODE_UTF8;
		end else if (cfg_we) begin
			source_mode_q <= cfg_mode;
		end
	end

	// sequence state, updated on each accepted transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_remaining_q <= 2'd0;
			code_acc_q        <= '0;
			halted_q          <= 1'b0;
		end else if (accept) begin
			bytes_remaining_q <= bytes_remaining_d;
			code_acc_q        <= code_acc_d;
			halted_q          <= halted_d;
		end
	end

endmodule

// ===== src/u8h_queue.sv =====
// short register queue of actions between front and back
`timescale 1ns / 1ps

module u8h_queue
	import u8h_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output logic   full,
	output logic   empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	entry_t            mem_q [DEPTH];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign full  = (count_q == CntW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// no push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue push while full");

	// no pop from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("queue pop while empty");

	// a lone push raises the fill count by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow push");

endmodule

// ===== src/u8h_back.sv =====
// back part: turns queued actions into result transfers through an output register
`timescale 1ns / 1ps

module u8h_back
	import u8h_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  entry_t     head,
	input  logic       empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [2:0] status,
	output logic       last
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic [2:0] status_q;
	logic       last_q;
	logic       pending_q;
	logic [7:0] pend_byte_q;
	logic       advance;

	assign advance   = !out_valid_q || out_ready;
	assign pop       = advance && !pending_q && !empty;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign status    = status_q;
	assign last      = last_q;

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pending_q   <= 1'b0;
		end else if (advance) begin
			if (pending_q) begin
				out_valid_q <= 1'b1;
				pending_q   <= 1'b0;
			end else begin
				out_valid_q <= !empty;
				pending_q   <= !empty && head.pair;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (advance) begin
			if (pending_q) begin
				out_byte_q <= pend_byte_q;
				status_q   <= ST_OK;
				last_q     <= 1'b1;
			end else if (head.pair) begin
				out_byte_q  <= head.b0;
				status_q    <= ST_OK;
				last_q      <= 1'b0;
				pend_byte_q <= head.b1;
			end else begin
				out_byte_q <= head.b1;
				status_q   <= head.status;
				last_q     <= 1'b1;
			end
		end
	end

	// a second byte waits only behind a shown first byte
	a_pend_shown: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> (out_valid_q && !last_q))
		else $error("pending byte without a first byte shown");

	// a first byte of a pair is always followed by its low byte
	a_first_has_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q) |-> pending_q)
		else $error("first byte of a pair without a pending low byte");

	// error results are single and carry a zero byte
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> (last_q && out_byte_q == 8'd0))
		else $error("error result not final or not zero");

endmodule
